// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the torque controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, codes and widths shared by the joint torque PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int FRAC_W  = 16;
  localparam int A_W     = 25;
  localparam int B_W     = 32;
  localparam int PROD_W  = A_W + B_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_COMPUTED = 2'd1;
  localparam logic [1:0] ST_FAULT    = 2'd2;

  typedef enum logic [2:0] {
    REG_POSITION_GAIN     = 3'd0,
    REG_VELOCITY_GAIN     = 3'd1,
    REG_INTEGRAL_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT    = 3'd3,
    REG_TORQUE_LIMIT      = 3'd4,
    REG_OUTPUT_ENABLE     = 3'd5,
    REG_MAX_READ_FAILURES = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_LOAD_RND,
    ACC_ADD_RND
  } acc_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_I,
    S_RND_I,
    S_INTEG,
    S_MUL_P,
    S_MUL_V,
    S_MUL_K,
    S_SUM,
    S_RND,
    S_SAT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               sensor_valid;
    logic signed [23:0] measured_position;
    logic signed [23:0] measured_velocity;
    logic signed [23:0] reference_position;
    logic signed [23:0] reference_velocity;
    logic [15:0]        elapsed_time;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [23:0] computed_torque;
    logic signed [23:0] applied_torque;
    logic               control_enabled;
  } out_t;

  typedef struct packed {
    logic [23:0] position_gain;
    logic [23:0] velocity_gain;
    logic [23:0] integral_gain;
    logic [30:0] integral_limit;
    logic [22:0] torque_limit;
    logic        output_enable;
    logic [3:0]  max_read_failures;
  } cfg_t;

  typedef struct packed {
    logic                  mul_en;
    acc_op_t               acc_op;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } mac_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/ptc_regs.sv
// ----------------------------------------------------------------------------
// ptc_regs
// APB-style configuration register file for the torque controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_regs import ptc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  reg_index_t idx;

  assign idx    = reg_index_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_gain     <= '0;
      cfg.velocity_gain     <= '0;
      cfg.integral_gain     <= '0;
      cfg.integral_limit    <= '0;
      cfg.torque_limit      <= '0;
      cfg.output_enable     <= 1'b0;
      cfg.max_read_failures <= 4'd3;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_POSITION_GAIN:     cfg.position_gain     <= pwdata[23:0];
        REG_VELOCITY_GAIN:     cfg.velocity_gain     <= pwdata[23:0];
        REG_INTEGRAL_GAIN:     cfg.integral_gain     <= pwdata[23:0];
        REG_INTEGRAL_LIMIT:    cfg.integral_limit    <= pwdata[30:0];
        REG_TORQUE_LIMIT:      cfg.torque_limit      <= pwdata[22:0];
        REG_OUTPUT_ENABLE:     cfg.output_enable     <= pwdata[0];
        REG_MAX_READ_FAILURES: cfg.max_read_failures <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POSITION_GAIN:     prdata = {8'd0, cfg.position_gain};
      REG_VELOCITY_GAIN:     prdata = {8'd0, cfg.velocity_gain};
      REG_INTEGRAL_GAIN:     prdata = {8'd0, cfg.integral_gain};
      REG_INTEGRAL_LIMIT:    prdata = {1'b0, cfg.integral_limit};
      REG_TORQUE_LIMIT:      prdata = {9'd0, cfg.torque_limit};
      REG_OUTPUT_ENABLE:     prdata = {31'd0, cfg.output_enable};
      REG_MAX_READ_FAILURES: prdata = {28'd0, cfg.max_read_failures};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ptc_mac.sv
// ----------------------------------------------------------------------------
// ptc_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_mac import ptc_pkg::*; (
  input  wire logic                    clk,
  input  wire mac_req_t                req,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod <= req.a * req.b;
    end
  end

  always_ff @(posedge clk) begin
    case (req.acc_op)
      ACC_LOAD:     acc <= prod_ext;
      ACC_ADD:      acc <= acc + prod_ext;
      ACC_LOAD_RND: acc <= prod_ext + RND_HALF;
      ACC_ADD_RND:  acc <= acc + RND_HALF;
      default:      acc <= acc;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/pid_torque_with_clamps.sv
// ----------------------------------------------------------------------------
// pid_torque_with_clamps
// Joint torque PID with integral clamp, torque saturation and read-fault stop.
// ----------------------------------------------------------------------------
// Sequencing: command items and non-computing ticks go straight to S_DONE; a
//   computing tick steps through S_MUL_P, S_MUL_V, S_MUL_K, S_SUM, S_RND and S_SAT
//   to S_DONE, led by S_MUL_I, S_RND_I and S_INTEG with output enabled. One item
//   at a time uses the shared multiplier and accumulator; tick_stall is high while busy.
// Reset (rst, synchronous): control stopped, integral, failure count and held
//   measurement cleared, registers at their reset values, no result pending.
`default_nettype none
`include "assert_macros.svh"

module pid_torque_with_clamps import ptc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               tick_valid,
  output logic                    tick_stall,
  input  wire in_t                tick_data,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output out_t                    result_data
);

  cfg_t                     cfg;
  mac_req_t                 mac_req;
  logic signed [ACC_W-1:0]  acc;

  state_t             state, state_next;
  logic               enabled;
  logic signed [31:0] integ;
  logic [4:0]         fcnt;
  logic signed [23:0] held_pos, held_vel;
  logic signed [24:0] err_p, err_v;
  logic [15:0]        dt;
  logic [1:0]         res_status;
  logic signed [23:0] res_torque, res_applied;

  logic               tick_acc, out_load, fault, run;
  logic [4:0]         fcnt_inc;
  logic signed [23:0] pos_used, vel_used;
  logic signed [25:0] inc;
  logic signed [32:0] isum, ilim;
  logic signed [31:0] integ_next;
  logic signed [42:0] q;
  logic signed [43:0] tneg, tlim;
  logic signed [23:0] torque_sat;

  ptc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptc_mac u_mac (
    .clk  (clk),
    .req  (mac_req),
    .acc  (acc)
  );

  assign tick_stall = (state != S_IDLE);
  assign tick_acc   = tick_valid && !tick_stall;
  assign out_load   = (state == S_DONE) && (!result_valid || !result_stall);

  // Item decode at acceptance
  assign fcnt_inc = (fcnt == 5'd31) ? fcnt : fcnt + 5'd1;
  assign fault    = fcnt_inc > {1'b0, cfg.max_read_failures};
  assign pos_used = tick_data.sensor_valid ? tick_data.measured_position : held_pos;
  assign vel_used = tick_data.sensor_valid ? tick_data.measured_velocity : held_vel;
  assign run      = (cmd_t'(tick_data.command) == CMD_TICK) && enabled &&
                    (tick_data.sensor_valid || !fault);

  // Integral update: round the dt*e product to Q16.16, add, clamp
  assign inc  = $signed(acc[41:FRAC_W]);
  assign isum = {integ[31], integ} + {{7{inc[25]}}, inc};
  assign ilim = $signed({2'b00, cfg.integral_limit});
  always_comb begin
    if (isum > ilim) begin
      integ_next = ilim[31:0];
    end else if (isum < -ilim) begin
      integ_next = 32'(-ilim);
    end else begin
      integ_next = isum[31:0];
    end
  end

  // Torque: negate the rounded sum, saturate
  assign q    = $signed(acc[ACC_W-1:FRAC_W]);
  assign tneg = -{q[42], q};
  assign tlim = $signed({21'd0, cfg.torque_limit});
  always_comb begin
    if (tneg > tlim) begin
      torque_sat = tlim[23:0];
    end else if (tneg < -tlim) begin
      torque_sat = 24'(-tlim);
    end else begin
      torque_sat = tneg[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    mac_req.mul_en = 1'b0;
    mac_req.acc_op = ACC_HOLD;
    mac_req.a      = '0;
    mac_req.b      = '0;
    case (state)
      S_IDLE: begin
        if (tick_acc) begin
          if (run) begin
            state_next = cfg.output_enable ? S_MUL_I : S_MUL_P;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL_I: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = $signed({9'd0, dt});
        mac_req.b      = 32'(err_p);
        state_next     = S_RND_I;
      end
      S_RND_I: begin
        mac_req.acc_op = ACC_LOAD_RND;
        state_next     = S_INTEG;
      end
      S_INTEG: begin
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = $signed({1'b0, cfg.position_gain});
        mac_req.b      = 32'(err_p);
        state_next     = S_MUL_V;
      end
      S_MUL_V: begin
        mac_req.mul_en = 1'b1;
        mac_req.acc_op = ACC_LOAD;
        mac_req.a      = $signed({1'b0, cfg.velocity_gain});
        mac_req.b      = 32'(err_v);
        state_next     = S_MUL_K;
      end
      S_MUL_K: begin
        mac_req.mul_en = 1'b1;
        mac_req.acc_op = ACC_ADD;
        mac_req.a      = $signed({1'b0, cfg.integral_gain});
        mac_req.b      = integ;
        state_next     = S_SUM;
      end
      S_SUM: begin
        mac_req.acc_op = ACC_ADD;
        state_next     = S_RND;
      end
      S_RND: begin
        mac_req.acc_op = ACC_ADD_RND;
        state_next     = S_SAT;
      end
      S_SAT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b0;
      integ    <= '0;
      fcnt     <= '0;
      held_pos <= '0;
      held_vel <= '0;
    end else if (tick_acc) begin
      case (cmd_t'(tick_data.command))
        CMD_START: begin
          if (!enabled) begin
            enabled <= 1'b1;
            fcnt    <= '0;
          end
        end
        CMD_STOP: begin
          enabled <= 1'b0;
        end
        CMD_CLEAR: begin
          integ <= '0;
        end
        CMD_TICK: begin
          if (enabled) begin
            if (!tick_data.sensor_valid) begin
              fcnt <= fcnt_inc;
              if (fault) begin
                enabled <= 1'b0;
              end
            end else begin
              fcnt     <= '0;
              held_pos <= tick_data.measured_position;
              held_vel <= tick_data.measured_velocity;
            end
          end
        end
        default: ;
      endcase
    end else if (state == S_INTEG) begin
      integ <= integ_next;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      err_p       <= 25'(pos_used) - 25'(tick_data.reference_position);
      err_v       <= 25'(vel_used) - 25'(tick_data.reference_velocity);
      dt          <= tick_data.elapsed_time;
      res_torque  <= '0;
      res_applied <= '0;
      if ((cmd_t'(tick_data.command) == CMD_TICK) && enabled &&
          !tick_data.sensor_valid && fault) begin
        res_status <= ST_FAULT;
      end else begin
        res_status <= ST_IDLE;
      end
    end else if (state == S_SAT) begin
      res_status  <= ST_COMPUTED;
      res_torque  <= torque_sat;
      res_applied <= cfg.output_enable ? torque_sat : '0;
    end
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_data.status          <= res_status;
      result_data.computed_torque <= res_torque;
      result_data.applied_torque  <= res_applied;
      result_data.control_enabled <= enabled;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, tick_acc, tick_stall,
               "item accepted but input not stalled next cycle")

  `ASSERT_IMPLY(a_fault_stops, clk, rst,
                result_valid && (result_data.status == ST_FAULT),
                !result_data.control_enabled,
                "read fault result with control still enabled")

  `ASSERT_IMPLY(a_applied_needs_compute, clk, rst,
                result_valid && (result_data.applied_torque != '0),
                result_data.status == ST_COMPUTED,
                "nonzero applied torque without computed status")

  `ASSERT_NEXT(a_integral_clamped, clk, rst, state == S_INTEG,
               ($signed({1'b0, integ}) <= ilim) && ($signed({1'b0, integ}) >= -ilim) ||
               ($signed({integ[31], integ}) <= ilim) && ($signed({integ[31], integ}) >= -ilim),
               "integral outside its limit after update")

endmodule

`default_nettype wire
